// ===== src/bls_pkg.sv =====
// Shared types and codes for the bounded LIFO stack core.
// No dependencies; imported by the controller, datapath and top level.
package bls_pkg;

   localparam int WORD_W = 32;

   // request codes
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_DUMP = 2'd2;
   localparam logic [1:0] REQ_PEEK = 2'd3;

   // response status codes
   localparam logic [1:0] RSP_OK    = 2'd0;
   localparam logic [1:0] RSP_FULL  = 2'd1;
   localparam logic [1:0] RSP_EMPTY = 2'd2;

   typedef enum logic [0:0] {
      CTL_IDLE,
      CTL_DUMP
   } ctl_state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_PUSH,
      DP_REJECT_FULL,
      DP_REJECT_EMPTY,
      DP_POP,
      DP_PEEK,
      DP_DUMP_FIRST,
      DP_DUMP_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;      // stack holds DEPTH words
      logic empty;     // stack holds nothing
      logic fill_one;  // stack holds exactly one word
      logic ptr_one;   // dump has one word left to emit
   } dp_status_type;

endpackage

// ===== src/bls_ctl.sv =====
// Controller state machine for the bounded LIFO stack core.
// Depends on bls_pkg; drives the datapath through dp_cmd_type.
module bls_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_type,
   input  bls_pkg::dp_status_type dp_status,
   output bls_pkg::dp_cmd_type    dp_cmd,
   output logic                   busy
);
   import bls_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = DP_NONE;
      busy      = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               unique case (req_type)
                  REQ_PUSH: begin
                     dp_cmd.op = dp_status.full ? DP_REJECT_FULL : DP_PUSH;
                  end
                  REQ_POP: begin
                     dp_cmd.op = dp_status.empty ? DP_REJECT_EMPTY : DP_POP;
                  end
                  REQ_PEEK: begin
                     dp_cmd.op = dp_status.empty ? DP_REJECT_EMPTY : DP_PEEK;
                  end
                  REQ_DUMP: begin
                     if (dp_status.empty) begin
                        dp_cmd.op = DP_REJECT_EMPTY;
                     end else begin
                        dp_cmd.op = DP_DUMP_FIRST;
                        // stay in the dump loop only if more words remain
                        if (!dp_status.fill_one) begin
                           state_in = CTL_DUMP;
                        end
                     end
                  end
                  default: begin
                     dp_cmd.op = DP_NONE;
                  end
               endcase
            end
         end
         CTL_DUMP: begin
            busy      = 1'b1;
            dp_cmd.op = DP_DUMP_NEXT;
            if (dp_status.ptr_one) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

// ===== src/bls_dp.sv =====
// Datapath for the bounded LIFO stack core: word store, fill count,
// dump pointer and response registers. Depends on bls_pkg.
module bls_dp #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bls_pkg::dp_cmd_type           dp_cmd,
   input  logic signed [bls_pkg::WORD_W-1:0] push_value,
   output bls_pkg::dp_status_type        dp_status,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic signed [bls_pkg::WORD_W-1:0] rsp_data_word,
   output logic                          rsp_last
);
   import bls_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] data_ff;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             strobe_ff, strobe_in;
   logic [1:0]       status_ff, status_in;
   logic             last_ff, last_in;

   logic              wr_en;
   logic              rd_en;
   logic [CNT_W-1:0]  fill_dec;
   logic [CNT_W-1:0]  ptr_dec;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   assign fill_dec = fill_ff - CNT_W'(1);
   assign ptr_dec  = ptr_ff - CNT_W'(1);
   assign wr_addr  = fill_ff[ADDR_W-1:0];

   assign dp_status.full     = (fill_ff == CNT_W'(DEPTH));
   assign dp_status.empty    = (fill_ff == '0);
   assign dp_status.fill_one = (fill_ff == CNT_W'(1));
   assign dp_status.ptr_one  = (ptr_ff == CNT_W'(1));

   always_comb begin
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = fill_dec[ADDR_W-1:0];
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      strobe_in = 1'b0;
      status_in = RSP_OK;
      last_in   = 1'b1;
      unique case (dp_cmd.op)
         DP_NONE: begin
         end
         DP_PUSH: begin
            wr_en     = 1'b1;
            fill_in   = fill_ff + CNT_W'(1);
            strobe_in = 1'b1;
         end
         DP_REJECT_FULL: begin
            strobe_in = 1'b1;
            status_in = RSP_FULL;
         end
         DP_REJECT_EMPTY: begin
            strobe_in = 1'b1;
            status_in = RSP_EMPTY;
         end
         DP_POP: begin
            rd_en     = 1'b1;
            fill_in   = fill_dec;
            strobe_in = 1'b1;
         end
         DP_PEEK: begin
            rd_en     = 1'b1;
            strobe_in = 1'b1;
         end
         DP_DUMP_FIRST: begin
            rd_en     = 1'b1;
            ptr_in    = fill_dec;
            strobe_in = 1'b1;
            last_in   = dp_status.fill_one;
         end
         DP_DUMP_NEXT: begin
            rd_en     = 1'b1;
            rd_addr   = ptr_dec[ADDR_W-1:0];
            ptr_in    = ptr_dec;
            strobe_in = 1'b1;
            last_in   = dp_status.ptr_one;
         end
         default: begin
         end
      endcase
   end

   // word store with registered read; zero the read word when nothing is read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end else begin
         data_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         ptr_ff    <= ptr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_data_word = data_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== src/bounded_lifo_stack_core.sv =====
// Top level of the bounded LIFO stack core: controller plus datapath.
// Depends on bls_pkg, bls_ctl and bls_dp.
//
//   channel   ports                                        transfer when
//   request   start, busy, req_type, req_push_value        start && !busy
//   response  rsp_strobe, rsp_status, rsp_data_word,       rsp_strobe
//             rsp_last
//
// Push, pop, peek and any rejected request give one response in the cycle
// after the request; busy stays low, so a new request may follow every cycle.
// Dump on a stack of N words streams N responses, one per cycle, from the
// cycle after the request; busy stays high until the final response, set by
// the single read port of the word store.
// Reset empties the stack at once; stored words are not cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.
module bounded_lifo_stack_core #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic signed [bls_pkg::WORD_W-1:0] req_push_value,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic signed [bls_pkg::WORD_W-1:0] rsp_data_word,
   output logic                              rsp_last
);
   import bls_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   bls_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   bls_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .push_value    (req_push_value),
      .dp_status     (dp_status),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_data_word (rsp_data_word),
      .rsp_last      (rsp_last)
   );

   // every accepted request answers in the next cycle
   a_req_answered: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe)
      else $error("accepted request gave no response");

   // a final response frees the request side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> !busy)
      else $error("busy still high on final response");

   // only a running dump gives non-final responses
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy && rsp_status == RSP_OK)
      else $error("non-final response outside a dump");

   // rejected requests carry a zero word
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != RSP_OK |-> rsp_data_word == '0)
      else $error("rejected request carries a data word");

endmodule

// ===== tb/sv/bounded_lifo_stack_core_tb.sv =====
// Self-checking testbench for bounded_lifo_stack_core: directed table, then random traffic.
// Depends on bls_pkg and the core RTL. A built-in stack model predicts every response.
module bounded_lifo_stack_core_tb;
   import bls_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 410;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] word;
      logic              last;
   } rsp_item_type;

   // one row of the directed table; typed rows carry their own single response
   typedef struct packed {
      logic [1:0]        op;
      logic [WORD_W-1:0] val;
      bit                rnd_val;
      bit [7:0]          reps;
      bit                typed;
      logic [1:0]        status;
      logic [WORD_W-1:0] word;
   } drill_row_type;

   localparam int NUM_ROWS = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = REQ_PUSH;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic signed [WORD_W-1:0] rsp_data_word;
   logic rsp_last;

   logic [WORD_W-1:0] stack_words [DEPTH];
   int                stack_fill;
   rsp_item_type      pending_rsps [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;

   drill_row_type drill_rows [NUM_ROWS] = '{
      '{REQ_POP,  32'h0,        1'b0, 8'd1,  1'b1, RSP_EMPTY, 32'h0},
      '{REQ_PEEK, 32'h0,        1'b0, 8'd1,  1'b1, RSP_EMPTY, 32'h0},
      '{REQ_DUMP, 32'h0,        1'b0, 8'd1,  1'b1, RSP_EMPTY, 32'h0},
      '{REQ_PUSH, 32'h7FFFFFFF, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h0},
      '{REQ_PEEK, 32'h0,        1'b0, 8'd1,  1'b1, RSP_OK,    32'h7FFFFFFF},
      '{REQ_PUSH, 32'h80000000, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h0},
      '{REQ_PEEK, 32'hFFFFFFFF, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h80000000},
      '{REQ_POP,  32'h0,        1'b0, 8'd1,  1'b1, RSP_OK,    32'h80000000},
      '{REQ_PUSH, 32'h00000000, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h0},
      '{REQ_PUSH, 32'hFFFFFFFF, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h0},
      '{REQ_DUMP, 32'h0,        1'b0, 8'd1,  1'b0, RSP_OK,    32'h0},
      '{REQ_PUSH, 32'h0,        1'b1, 8'd13, 1'b0, RSP_OK,    32'h0},
      '{REQ_PUSH, 32'h12345678, 1'b0, 8'd1,  1'b1, RSP_FULL,  32'h0},
      '{REQ_DUMP, 32'h0,        1'b0, 8'd1,  1'b0, RSP_OK,    32'h0},
      '{REQ_PEEK, 32'h0,        1'b0, 8'd1,  1'b0, RSP_OK,    32'h0},
      '{REQ_POP,  32'h0,        1'b0, 8'd16, 1'b0, RSP_OK,    32'h0},
      '{REQ_POP,  32'h0,        1'b0, 8'd1,  1'b1, RSP_EMPTY, 32'h0},
      '{REQ_DUMP, 32'h0,        1'b0, 8'd1,  1'b1, RSP_EMPTY, 32'h0},
      '{REQ_PUSH, 32'hAAAAAAAA, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h0},
      '{REQ_PUSH, 32'h55555555, 1'b0, 8'd1,  1'b1, RSP_OK,    32'h0},
      '{REQ_POP,  32'h0,        1'b0, 8'd1,  1'b1, RSP_OK,    32'h55555555},
      '{REQ_PEEK, 32'h0,        1'b0, 8'd1,  1'b1, RSP_OK,    32'hAAAAAAAA},
      '{REQ_DUMP, 32'h0,        1'b0, 8'd1,  1'b1, RSP_OK,    32'hAAAAAAAA},
      '{REQ_POP,  32'h0,        1'b0, 8'd1,  1'b1, RSP_OK,    32'hAAAAAAAA}
   };

   bounded_lifo_stack_core #(.DEPTH(DEPTH)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_data_word  (rsp_data_word),
      .rsp_last       (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Append the responses a request causes and advance the stack model.
   function automatic void predict_stack_rsps(input logic [1:0] op, input logic [WORD_W-1:0] val);
      rsp_item_type r;
      int pos;
      r.status = RSP_OK;
      r.word   = '0;
      r.last   = 1'b1;
      if (op == REQ_PUSH) begin
         if (stack_fill >= DEPTH) begin
            r.status = RSP_FULL;
         end else begin
            stack_words[stack_fill] = val;
            stack_fill++;
         end
         pending_rsps.push_back(r);
      end else if (stack_fill == 0) begin
         r.status = RSP_EMPTY;
         pending_rsps.push_back(r);
      end else if (op == REQ_POP) begin
         stack_fill--;
         r.word = stack_words[stack_fill];
         pending_rsps.push_back(r);
      end else if (op == REQ_PEEK) begin
         r.word = stack_words[stack_fill - 1];
         pending_rsps.push_back(r);
      end else begin
         // dump: top down to the bottom word, which alone carries last
         for (pos = stack_fill - 1; pos >= 0; pos--) begin
            r.word = stack_words[pos];
            r.last = (pos == 0);
            pending_rsps.push_back(r);
         end
      end
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 7))
         0: w = 32'h7FFFFFFF;
         1: w = 32'h80000000;
         2: w = ($urandom_range(0, 1) == 1) ? 32'hFFFFFFFF : 32'h0;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Hold start until the transfer happens, then predict its responses.
   task automatic send_request(input logic [1:0] op, input logic [WORD_W-1:0] val);
      start          <= 1'b1;
      req_type       <= op;
      req_push_value <= val;
      do @(posedge clock); while (busy);
      predict_stack_rsps(op, val);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start          <= 1'b0;
         req_type       <= 2'($urandom);
         req_push_value <= $urandom;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // with nothing outstanding, start is already low
   task automatic hold_until_drained();
      if (pending_rsps.size() != 0) begin
         start <= 1'b0;
         while (pending_rsps.size() != 0) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d data %h last %b",
                        rsp_status, rsp_data_word, rsp_last);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_status !== want.status || rsp_data_word !== want.word ||
                rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d data %h last %b, got %0d %h %b",
                           want.status, want.word, want.last,
                           rsp_status, rsp_data_word, rsp_last);
            end
         end
      end
   end

   initial begin
      int row;
      int k;
      int sent;
      int phase_len;
      int push_pct;
      int pop_pct;
      int peek_pct;
      int pick;
      bit quiet;
      logic [1:0] op;
      logic [WORD_W-1:0] val;
      rsp_item_type typed_rsp;

      stack_fill = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < NUM_ROWS; row++) begin
         for (k = 0; k < drill_rows[row].reps; k++) begin
            val = drill_rows[row].rnd_val ? pick_word() : drill_rows[row].val;
            send_request(drill_rows[row].op, val);
            if (drill_rows[row].typed) begin
               // replace the predicted response with the one typed in the table
               typed_rsp.status = drill_rows[row].status;
               typed_rsp.word   = drill_rows[row].word;
               typed_rsp.last   = 1'b1;
               pending_rsps[pending_rsps.size() - 1] = typed_rsp;
            end
            idle_for(pick_gap(1'b0));
         end
      end
      hold_until_drained();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 60);
         quiet     = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: begin push_pct = 70; pop_pct = 10; peek_pct = 10; end
            1: begin push_pct = 15; pop_pct = 65; peek_pct = 10; end
            2: begin push_pct = 40; pop_pct = 30; peek_pct = 15; end
            default: begin push_pct = 35; pop_pct = 20; peek_pct = 15; end
         endcase
         for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
               op = REQ_PUSH;
            else if (pick < push_pct + pop_pct)
               op = REQ_POP;
            else if (pick < push_pct + pop_pct + peek_pct)
               op = REQ_PEEK;
            else
               op = REQ_DUMP;
            send_request(op, pick_word());
            sent++;
            idle_for(pick_gap(quiet));
         end
         if ($urandom_range(0, 3) == 0)
            hold_until_drained();
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== bounded_lifo_stack_core.f =====
src/bls_pkg.sv
src/bls_ctl.sv
src/bls_dp.sv
src/bounded_lifo_stack_core.sv
tb/sv/bounded_lifo_stack_core_tb.sv
